>>> rtl/lmfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmfs_pkg;

	// storage defaults and fixed limits
	localparam int MaxColumnsDefault = 64;
	localparam int RefreshLimit      = 64;
	localparam int RefreshW          = 7;
	localparam int CountW            = 7;
	localparam logic [CountW-1:0] ColumnCountReset = 7'd8;

	// command codes
	typedef logic [2:0] req_t;
	localparam req_t REQ_INIT    = 3'd0;
	localparam req_t REQ_ROW     = 3'd1;
	localparam req_t REQ_SET     = 3'd2;
	localparam req_t REQ_CLEAR   = 3'd3;
	localparam req_t REQ_WRITE   = 3'd4;
	localparam req_t REQ_READ    = 3'd5;
	localparam req_t REQ_SHIFT   = 3'd6;
	localparam req_t REQ_REFRESH = 3'd7;

	localparam logic [2:0] InitLastIdx = 3'd5;

	// classified command as it sits in the queue
	typedef struct packed {
		req_t       op;
		logic [5:0] column;
		logic [2:0] bit_index;
		logic [7:0] value;
		logic [3:0] row_address;
		logic       rd_ok;
	} cmd_t;

	// one result beat
	typedef struct packed {
		logic       word_valid;
		logic       frame_start;
		logic       frame_end;
		logic [3:0] reg_address;
		logic [7:0] reg_data;
		logic [7:0] read_data;
		logic       last;
	} res_t;

	// setup sequence: {address, data}
	function automatic logic [11:0] init_word(input logic [2:0] idx);
		logic [11:0] w;
		unique case (idx)
			3'd0: w = {4'h9, 8'h00};
			3'd1: w = {4'ha, 8'h01};
			3'd2: w = {4'hb, 8'h07};
			3'd3: w = {4'hc, 8'h01};
			3'd4: w = {4'hf, 8'h00};
			default: w = {4'h0, 8'h00};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lmfs_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lmfs_front import lmfs_pkg::*; #(
	parameter int MAX_COLUMNS = MaxColumnsDefault,
	parameter int NW = $clog2(MAX_COLUMNS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [2:0]    req_type,
	input  wire logic [5:0]    column,
	input  wire logic [2:0]    bit_index,
	input  wire logic [7:0]    value,
	input  wire logic [7:0]    row_address,
	input  wire logic [NW-1:0] n,
	output cmd_t               head,
	output logic               head_valid,
	input  wire logic          pop
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       keep;
	logic       push;
	logic       col_ok;
	cmd_t       cmd;

	assign col_ok = int'(column) < int'(n);

	// drop commands that cannot have any effect
	always_comb begin
		unique case (req_type)
			REQ_INIT:            keep = 1'b1;
			REQ_ROW:             keep = (row_address >= 8'd1) && (row_address <= 8'd8);
			REQ_SET, REQ_CLEAR,
			REQ_WRITE:           keep = col_ok;
			REQ_READ:            keep = 1'b1;
			REQ_SHIFT:           keep = int'(n) >= 2;
			default:             keep = int'(n) >= 8;
		endcase
	end

	always_comb begin
		cmd.op          = req_type;
		cmd.column      = column;
		cmd.bit_index   = bit_index;
		cmd.value       = value;
		cmd.row_address = row_address[3:0];
		cmd.rd_ok       = int'(column) < MAX_COLUMNS;
	end

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy && keep;
	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/lmfs_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lmfs_back import lmfs_pkg::*; #(
	parameter int MAX_COLUMNS = MaxColumnsDefault,
	parameter int NW = $clog2(MAX_COLUMNS + 1),
	parameter int AW = $clog2(MAX_COLUMNS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [NW-1:0] n,
	input  cmd_t               head,
	input  wire logic          head_valid,
	output logic               pop,
	output logic               strobe,
	output res_t               res
);

	localparam int IW = NW + 1;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_INIT    = 4'd1;
	localparam logic [3:0] ST_RMW     = 4'd2;
	localparam logic [3:0] ST_READOUT = 4'd3;
	localparam logic [3:0] ST_SH_RD   = 4'd4;
	localparam logic [3:0] ST_SH_WR   = 4'd5;
	localparam logic [3:0] ST_RF_RD   = 4'd6;
	localparam logic [3:0] ST_RF_ACC  = 4'd7;

	logic [3:0]          state_q;
	cmd_t                cmd_q;
	logic [2:0]          idx_q;
	logic [AW-1:0]       i_q;
	logic [2:0]          r_q;
	logic [3:0]          s_q;
	logic [3:0]          segs_q;
	logic [2:0]          k_q;
	logic [RefreshW-1:0] base_q;
	logic [7:0]          acc_q;

	logic [7:0]          mem_q [MAX_COLUMNS];
	logic [MAX_COLUMNS-1:0] valid_q;
	logic [7:0]          rd_data_q;
	logic                rd_vld_q;

	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [7:0]          wr_data;
	logic [7:0]          cur;
	logic [7:0]          mask;
	logic [RefreshW-1:0] m;
	logic [RefreshW-1:0] rf_col;
	logic [7:0]          acc_next;
	logic                seg_last;
	logic [11:0]         iw;

	assign cur      = rd_vld_q ? rd_data_q : 8'd0;
	assign mask     = 8'd1 << cmd_q.bit_index;
	assign m        = (int'(n) > RefreshLimit) ? RefreshW'(RefreshLimit) : RefreshW'(n);
	assign rf_col   = base_q + RefreshW'(k_q);
	assign acc_next = acc_q | (8'(cur[3'd7 - r_q]) << k_q);
	assign seg_last = (s_q == segs_q - 4'd1);
	assign iw       = init_word(idx_q);
	assign pop      = (state_q == ST_IDLE) && head_valid;

	// memory port selection
	always_comb begin
		rd_addr = AW'(head.column);
		wr_en   = 1'b0;
		wr_addr = AW'(head.column);
		wr_data = head.value;
		unique case (state_q)
			ST_IDLE: begin
				wr_en = pop && (head.op == REQ_WRITE);
			end
			ST_RMW: begin
				wr_en   = 1'b1;
				wr_addr = AW'(cmd_q.column);
				wr_data = (cmd_q.op == REQ_SET) ? (cur | mask) : (cur & ~mask);
			end
			ST_SH_RD: begin
				rd_addr = i_q + AW'(1);
			end
			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = cur;
			end
			ST_RF_RD: begin
				rd_addr = AW'(rf_col);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			strobe  <= 1'b0;
			res     <= '0;
			cmd_q   <= '0;
			idx_q   <= '0;
			i_q     <= '0;
			r_q     <= '0;
			s_q     <= '0;
			segs_q  <= '0;
			k_q     <= '0;
			base_q  <= '0;
			acc_q   <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						cmd_q <= head;
						unique case (head.op)
							REQ_INIT: begin
								idx_q   <= '0;
								state_q <= ST_INIT;
							end
							REQ_ROW: begin
								strobe <= 1'b1;
								res    <= '{word_valid: 1'b1, frame_start: 1'b1,
									frame_end: 1'b1, reg_address: head.row_address,
									reg_data: head.value, read_data: 8'd0, last: 1'b1};
							end
							REQ_SET, REQ_CLEAR: state_q <= ST_RMW;
							REQ_WRITE:          state_q <= ST_IDLE;
							REQ_READ:           state_q <= ST_READOUT;
							REQ_SHIFT: begin
								i_q     <= '0;
								state_q <= ST_SH_RD;
							end
							default: begin
								r_q     <= '0;
								s_q     <= '0;
								k_q     <= '0;
								acc_q   <= '0;
								base_q  <= m - RefreshW'(8);
								segs_q  <= m[RefreshW-1:3];
								state_q <= ST_RF_RD;
							end
						endcase
					end
				end
				ST_INIT: begin
					strobe <= 1'b1;
					res    <= '{word_valid: 1'b1, frame_start: 1'b1, frame_end: 1'b1,
						reg_address: iw[11:8], reg_data: iw[7:0], read_data: 8'd0,
						last: (idx_q == InitLastIdx)};
					idx_q  <= idx_q + 3'd1;
					if (idx_q == InitLastIdx) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RMW: begin
					state_q <= ST_IDLE;
				end
				ST_READOUT: begin
					strobe  <= 1'b1;
					res     <= '{word_valid: 1'b0, frame_start: 1'b0, frame_end: 1'b0,
						reg_address: 4'd0, reg_data: 8'd0,
						read_data: (cmd_q.rd_ok ? cur : 8'd0), last: 1'b1};
					state_q <= ST_IDLE;
				end
				ST_SH_RD: begin
					state_q <= ST_SH_WR;
				end
				ST_SH_WR: begin
					if (IW'(i_q) + IW'(2) == IW'(n)) begin
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_SH_RD;
					end
				end
				ST_RF_RD: begin
					state_q <= ST_RF_ACC;
				end
				ST_RF_ACC: begin
					if (k_q == 3'd7) begin
						strobe <= 1'b1;
						res    <= '{word_valid: 1'b1, frame_start: (s_q == 4'd0),
							frame_end: seg_last, reg_address: 4'(r_q) + 4'd1,
							reg_data: acc_next, read_data: 8'd0,
							last: seg_last && (r_q == 3'd7)};
						k_q    <= '0;
						acc_q  <= '0;
						if (seg_last) begin
							s_q    <= '0;
							base_q <= m - RefreshW'(8);
							r_q    <= r_q + 3'd1;
							state_q <= (r_q == 3'd7) ? ST_IDLE : ST_RF_RD;
						end else begin
							s_q     <= s_q + 4'd1;
							base_q  <= base_q - RefreshW'(8);
							state_q <= ST_RF_RD;
						end
					end else begin
						k_q     <= k_q + 3'd1;
						acc_q   <= acc_next;
						state_q <= ST_RF_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/led_matrix_frame_serializer_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// command   | start / busy         | req_type, column, bit_index, value, row_address
// result    | result_strobe        | word_valid, frame_start, frame_end, reg_address,
//           |                      | reg_data, read_data, last
// config    | cfg_wr_en            | cfg_wr_data (column_count)
//
// a command beat is taken when start is high and busy is low; it lands in a
// two-entry queue and the back end picks it up once its sequencer is idle
// the back end takes one command at a time from the queue; its pace is set
// by the column store, which has one read port and one write port (one
// registered read per column, eight reads per word)
// reset clears the queue, the sequencer and the column valid bits at once,
// so the store reads as zero with no clearing pass
// busy is high only while the queue holds two commands; results are shown
// for one cycle and the receiver cannot stall them

module led_matrix_frame_serializer_top import lmfs_pkg::*; #(
	parameter int MAX_COLUMNS = MaxColumnsDefault
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        req_type,
	input  wire logic [5:0]        column,
	input  wire logic [2:0]        bit_index,
	input  wire logic [7:0]        value,
	input  wire logic [7:0]        row_address,
	input  wire logic              cfg_wr_en,
	input  wire logic [CountW-1:0] cfg_wr_data,
	output logic                   result_strobe,
	output logic                   word_valid,
	output logic                   frame_start,
	output logic                   frame_end,
	output logic [3:0]             reg_address,
	output logic [7:0]             reg_data,
	output logic [7:0]             read_data,
	output logic                   last
);

	// width of the effective column count, which can equal the store size
	localparam int NW = $clog2(MAX_COLUMNS + 1);

	logic [CountW-1:0] column_count_q;
	logic [NW-1:0]     n;
	cmd_t              head;
	logic              head_valid;
	logic              pop;
	res_t              res;

	// column count register, to be written only while the block is idle; the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= ColumnCountReset;
		end else if (cfg_wr_en) begin
			column_count_q <= cfg_wr_data;
		end
	end

	// counts above the store size saturate
	assign n = (int'(column_count_q) > MAX_COLUMNS) ? NW'(MAX_COLUMNS) : NW'(column_count_q);

	// front end: takes command beats, drops no-ops, queues the rest
	lmfs_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.NW(NW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.column     (column),
		.bit_index  (bit_index),
		.value      (value),
		.row_address(row_address),
		.n          (n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	// back end: column store and word sequencer
	lmfs_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.NW(NW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.n         (n),
		.head      (head),
		.head_valid(head_valid),
		.pop       (pop),
		.strobe    (result_strobe),
		.res       (res)
	);

	assign word_valid  = res.word_valid;
	assign frame_start = res.frame_start;
	assign frame_end   = res.frame_end;
	assign reg_address = res.reg_address;
	assign reg_data    = res.reg_data;
	assign read_data   = res.read_data;
	assign last        = res.last;

endmodule

`default_nettype wire
